// File: rtl/pbm_pkg.sv
// Shared types and fixed-point constants for the periodic band map pixel core.
// No dependencies; imported by pbm_horner and periodic_band_map_pixel_core.
`timescale 1ns / 1ps
`default_nettype none

package pbm_pkg;

    // Internal unsigned fraction format
    localparam int          Q         = 30;
    localparam logic [30:0] ONE_Q     = 31'h4000_0000;
    localparam logic [30:0] HALF_PI_Q = 31'd1686629713;
    localparam logic [29:0] LN2_Q     = 30'd744261118;

    // Range reduction of t by ln2: k is below K_LIMIT or u underflows to zero
    localparam int          K_LIMIT   = 40;
    localparam int          K_W       = 6;
    localparam int          KT_W      = 35;
    localparam logic [63:0] KT_LIM    = 64'(K_LIMIT) * 64'(LN2_Q);

    // Pixel flags that travel with the valid bit through the whole pipeline
    typedef struct packed {
        logic        inv;
        logic [16:0] cnt;
        logic        yneg;
        logic        xneg;
    } side_t;

    // One step of the restoring division of t by ln2
    typedef struct packed {
        logic [KT_W-1:0] rem;
        logic [K_W-1:0]  k;
        logic            big;
        logic [30:0]     s;
        logic [31:0]     s2;
    } kd_t;

    // Operands that ride along the series evaluation
    typedef struct packed {
        logic [29:0]    f;
        logic [K_W-1:0] k;
        logic           big;
        logic [30:0]    s;
        logic [31:0]    s2;
    } hcar_t;

endpackage

`default_nettype wire

// File: rtl/periodic_band_map_pixel_core.sv
// Periodic band map: one pixel word in, one mapped pixel word out, one word per cycle
// sustained while the output takes words. Depth is set by the 32-bit
// x mod period divider, the 12-step exp series and the final bit-serial quotient stages.
// Back-pressure freezes the whole pipeline; nothing is dropped or repeated.
// Reset clears all valid bits and loads band_period with 4.0 (262144).
// Depends on pbm_pkg, pbm_udiv and pbm_horner.
`timescale 1ns / 1ps
`default_nettype none

module periodic_band_map_pixel_core
    import pbm_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire         clk,
    input  wire         rst_n,
    // band period register
    input  wire         cfg_wr_en,
    input  wire  [19:0] cfg_wr_data,
    // pixel words in
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [87:0] s_axis_tdata,  // in_x[31:0], in_y[63:32], in_inversions[80:64]
    // mapped pixel words out
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [55:0] m_axis_tdata   // out_x[17:0], out_y[35:18], out_inversions[52:36]
);

    localparam logic signed [31:0] ONE_IN = 32'sd1 <<< FRAC_BITS;
    localparam int AY_W   = FRAC_BITS + 1;
    localparam int T_W    = 51 - FRAC_BITS;
    localparam int QB     = FRAC_BITS + 3;
    localparam int NUMD_W = 33 + FRAC_BITS;
    localparam int KD_N   = K_W;
    localparam int HS_N   = 12;
    // pipeline positions of the side flags
    localparam int P_MOD  = 32;
    localparam int P_D    = P_MOD + 3 + KD_N + 2 * HS_N + 2;
    localparam int SIDE_N = P_D + QB + 1;
    localparam int P_LAST = SIDE_N - 1;
    localparam logic [17:0] INV_XY = (FRAC_BITS > 17) ? 18'h20000 :
                                     18'(~(32'd1 << FRAC_BITS) + 32'd1);

    logic en;
    logic [19:0] band_period_reg;

    // ------------------------------------------------------------------
    // Stall control: the whole pipeline moves when the output can take a word
    assign en            = ~m_axis_tvalid | m_axis_tready;
    assign s_axis_tready = en;

    // Band period register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            band_period_reg <= 20'd262144;
        else if (cfg_wr_en)
            band_period_reg <= cfg_wr_data;
    end

    // ------------------------------------------------------------------
    // Input stage: unpack, validity check, magnitudes
    logic signed [31:0] x_in;
    logic signed [31:0] y_in;
    logic [16:0]        cnt_in;
    logic [31:0]        ax_next;
    logic [31:0]        ay_full;
    side_t              side_next;
    logic [31:0]        ax_reg;

    assign x_in   = s_axis_tdata[31:0];
    assign y_in   = s_axis_tdata[63:32];
    assign cnt_in = s_axis_tdata[80:64];

    always_comb
    begin
        ax_next        = x_in[31] ? 32'(-x_in) : 32'(x_in);
        ay_full        = y_in[31] ? 32'(-y_in) : 32'(y_in);
        side_next.inv  = cnt_in[16] | (y_in > ONE_IN) | (y_in < -ONE_IN);
        side_next.cnt  = cnt_in;
        side_next.yneg = y_in[31];
        side_next.xneg = x_in[31];
    end

    // valid bits and side flags run the full length
    logic [SIDE_N-1:0] vld_reg;
    side_t             side_reg [SIDE_N];
    logic [AY_W-1:0]   ay_reg   [P_MOD+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[SIDE_N-2:0], s_axis_tvalid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_next;
            ay_reg[0]   <= AY_W'(ay_full);
            ax_reg      <= ax_next;
        end
    end

    for (genvar i = 1; i < SIDE_N; i++) begin : g_side
        always_ff @(posedge clk)
        begin
            if (en)
                side_reg[i] <= side_reg[i-1];
        end
    end

    for (genvar i = 1; i <= P_MOD; i++) begin : g_ay
        always_ff @(posedge clk)
        begin
            if (en)
                ay_reg[i] <= ay_reg[i-1];
        end
    end

    // ------------------------------------------------------------------
    // |x| mod period
    logic [19:0] mod_rem;

    pbm_udiv #(
        .NUM_W (32),
        .DEN_W (20),
        .QUO_W (32)
    ) u_mod (
        .clk (clk),
        .en  (en),
        .num (ax_reg),
        .den (band_period_reg),
        .quo (),
        .rem (mod_rem)
    );

    // Reduced x into [0, period), scaled y
    logic [19:0] r_reg;
    logic [19:0] r_next;
    logic [30:0] s_r_reg;

    always_comb
    begin
        if (band_period_reg == 20'd0)
            r_next = '0;
        else if (side_reg[P_MOD].xneg && (mod_rem != 20'd0))
            r_next = band_period_reg - mod_rem;
        else
            r_next = mod_rem;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg   <= r_next;
            s_r_reg <= 31'((64'(ay_reg[P_MOD]) * 64'(HALF_PI_Q)) >> FRAC_BITS);
        end
    end

    // Scaled x, and s squared
    logic [T_W-1:0] t_reg;
    logic [30:0]    s_t_reg;
    logic [31:0]    s2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg   <= T_W'((64'(r_reg) * 64'(HALF_PI_Q)) >> FRAC_BITS);
            s_t_reg <= s_r_reg;
            s2_reg  <= 32'((64'(s_r_reg) * 64'(s_r_reg)) >> Q);
        end
    end

    // ------------------------------------------------------------------
    // t = k*ln2 + f, one bit of k per stage
    kd_t kd_reg [KD_N];

    for (genvar i = 0; i < KD_N; i++) begin : g_kdiv
        localparam logic [KT_W-1:0] LIM = KT_W'(LN2_Q) << (KD_N - 1 - i);
        kd_t  kd_in;
        kd_t  kd_next;
        logic ge;

        if (i == 0) begin : g_first
            logic big;
            assign big      = (64'(t_reg) >= KT_LIM);
            assign kd_in.rem = big ? '0 : KT_W'(t_reg);
            assign kd_in.k   = '0;
            assign kd_in.big = big;
            assign kd_in.s   = s_t_reg;
            assign kd_in.s2  = s2_reg;
        end else begin : g_next
            assign kd_in = kd_reg[i-1];
        end

        always_comb
        begin
            ge          = (kd_in.rem >= LIM);
            kd_next     = kd_in;
            kd_next.rem = ge ? (kd_in.rem - LIM) : kd_in.rem;
            kd_next.k   = {kd_in.k[K_W-2:0], ge};
        end

        always_ff @(posedge clk)
        begin
            if (en)
                kd_reg[i] <= kd_next;
        end
    end

    // ------------------------------------------------------------------
    // Series: exp(-f) over twelve steps, sin and cos over the last eight
    hcar_t       hb [HS_N+1];
    hcar_t       hc1_reg [HS_N];
    hcar_t       hc2_reg [HS_N];
    logic [30:0] ep [HS_N+1];
    logic [30:0] ts [9];
    logic [30:0] tc [9];

    assign hb[0].f   = 30'(kd_reg[KD_N-1].rem);
    assign hb[0].k   = kd_reg[KD_N-1].k;
    assign hb[0].big = kd_reg[KD_N-1].big;
    assign hb[0].s   = kd_reg[KD_N-1].s;
    assign hb[0].s2  = kd_reg[KD_N-1].s2;
    assign ep[0]     = ONE_Q;
    assign ts[0]     = ONE_Q;
    assign tc[0]     = ONE_Q;

    for (genvar j = 0; j < HS_N; j++) begin : g_series
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                hc1_reg[j] <= hb[j];
                hc2_reg[j] <= hc1_reg[j];
            end
        end
        assign hb[j+1] = hc2_reg[j];

        pbm_horner #(
            .DIVISOR (HS_N - j)
        ) u_exp (
            .clk   (clk),
            .en    (en),
            .x     (32'(hb[j].f)),
            .p_in  (ep[j]),
            .p_out (ep[j+1])
        );

        if (j >= 4) begin : g_trig
            localparam int KK = HS_N - j;
            pbm_horner #(
                .DIVISOR ((2 * KK) * (2 * KK + 1))
            ) u_sin (
                .clk   (clk),
                .en    (en),
                .x     (hb[j].s2),
                .p_in  (ts[j-4]),
                .p_out (ts[j-3])
            );
            pbm_horner #(
                .DIVISOR ((2 * KK - 1) * (2 * KK))
            ) u_cos (
                .clk   (clk),
                .en    (en),
                .x     (hb[j].s2),
                .p_in  (tc[j-4]),
                .p_out (tc[j-3])
            );
        end
    end

    // ------------------------------------------------------------------
    // u = e^-t, sin s, cos s
    logic [30:0] u_reg;
    logic [30:0] sn_reg;
    logic [30:0] cs_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg  <= hb[HS_N].big ? 31'd0 : (ep[HS_N] >> hb[HS_N].k);
            sn_reg <= 31'((64'(hb[HS_N].s) * 64'(ts[8])) >> Q);
            cs_reg <= tc[8];
        end
    end

    // u^2, 2u cos s, 2u sin s
    logic [30:0] u2_reg;
    logic [31:0] uc_reg;
    logic [31:0] us_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u2_reg <= 31'((64'(u_reg) * 64'(u_reg)) >> Q);
            uc_reg <= 32'((64'(u_reg) * 64'(cs_reg)) >> (Q - 1));
            us_reg <= 32'((64'(u_reg) * 64'(sn_reg)) >> (Q - 1));
        end
    end

    // Denominator and rounded numerators
    logic [32:0]       den_next;
    logic [32:0]       den_reg;
    logic [NUMD_W-1:0] numx_reg;
    logic [NUMD_W-1:0] numy_reg;

    assign den_next = 33'(ONE_Q) + 33'(u2_reg) + 33'(uc_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg  <= den_next;
            numx_reg <= (NUMD_W'(ONE_Q - u2_reg) << FRAC_BITS) + NUMD_W'(den_next >> 1);
            numy_reg <= (NUMD_W'(us_reg) << FRAC_BITS) + NUMD_W'(den_next >> 1);
        end
    end

    // ------------------------------------------------------------------
    // Final quotients
    logic [QB-1:0] qx;
    logic [QB-1:0] qy;

    pbm_udiv #(
        .NUM_W (NUMD_W),
        .DEN_W (33),
        .QUO_W (QB)
    ) u_divx (
        .clk (clk),
        .en  (en),
        .num (numx_reg),
        .den (den_reg),
        .quo (qx),
        .rem ()
    );

    pbm_udiv #(
        .NUM_W (NUMD_W),
        .DEN_W (33),
        .QUO_W (QB)
    ) u_divy (
        .clk (clk),
        .en  (en),
        .num (numy_reg),
        .den (den_reg),
        .quo (qy),
        .rem ()
    );

    // ------------------------------------------------------------------
    // Saturate, restore sign, mark invalid pixels
    logic [31:0] qx32;
    logic [31:0] qy32;
    logic [31:0] oyc;
    logic [17:0] ox_next;
    logic [17:0] oy_next;
    logic [16:0] ocnt_next;
    logic [17:0] ox_reg;
    logic [17:0] oy_reg;
    logic [16:0] ocnt_reg;
    side_t       side_last;

    assign side_last = side_reg[P_LAST];

    always_comb
    begin
        qx32 = 32'(qx);
        qy32 = 32'(qy);
        if (side_last.yneg)
            oyc = (qy32 > 32'd131072) ? 32'd131072 : qy32;
        else
            oyc = (qy32 > 32'd131071) ? 32'd131071 : qy32;
        if (side_last.inv)
        begin
            ox_next   = INV_XY;
            oy_next   = INV_XY;
            ocnt_next = 17'h1FFFF;
        end
        else
        begin
            ox_next   = (qx32 > 32'd131071) ? 18'h1FFFF : 18'(qx32);
            oy_next   = side_last.yneg ? 18'(-oyc) : 18'(oyc);
            ocnt_next = side_last.cnt;
        end
    end

    // Output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tvalid <= 1'b0;
        else if (en)
            m_axis_tvalid <= vld_reg[P_LAST];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ox_reg   <= ox_next;
            oy_reg   <= oy_next;
            ocnt_reg <= ocnt_next;
        end
    end

    assign m_axis_tdata = {3'b000, ocnt_reg, oy_reg, ox_reg};

endmodule

`default_nettype wire

// File: rtl/pbm_udiv.sv
// Pipelined restoring divider, one quotient bit per stage.
// Stand-alone; used by periodic_band_map_pixel_core for x mod period and the final quotients.
`timescale 1ns / 1ps
`default_nettype none

module pbm_udiv #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 20,
    parameter int QUO_W = 32
) (
    input  wire              clk,
    input  wire              en,
    input  wire [NUM_W-1:0]  num,
    input  wire [DEN_W-1:0]  den,
    output logic [QUO_W-1:0] quo,
    output logic [DEN_W-1:0] rem
);

    logic [DEN_W-1:0] rem_reg [QUO_W];
    logic [QUO_W-1:0] low_reg [QUO_W];
    logic [QUO_W-1:0] quo_reg [QUO_W];
    logic [DEN_W-1:0] den_reg [QUO_W];

    for (genvar i = 0; i < QUO_W; i++) begin : g_stage
        logic [DEN_W-1:0] rem_prev;
        logic [QUO_W-1:0] low_prev;
        logic [QUO_W-1:0] quo_prev;
        logic [DEN_W-1:0] den_prev;
        logic [DEN_W:0]   trial;
        logic             ge;
        logic [DEN_W-1:0] rem_next;

        // stage inputs: the ports for the first stage, the previous stage otherwise
        if (i == 0) begin : g_first
            assign rem_prev = DEN_W'((NUM_W + DEN_W)'(num) >> QUO_W);
            assign low_prev = QUO_W'(num);
            assign quo_prev = '0;
            assign den_prev = den;
        end else begin : g_next
            assign rem_prev = rem_reg[i-1];
            assign low_prev = low_reg[i-1];
            assign quo_prev = quo_reg[i-1];
            assign den_prev = den_reg[i-1];
        end

        // bring down one numerator bit, subtract when it fits
        always_comb
        begin
            trial    = {rem_prev, low_prev[QUO_W-1]};
            ge       = (trial >= {1'b0, den_prev});
            rem_next = ge ? DEN_W'(trial - {1'b0, den_prev}) : DEN_W'(trial);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= rem_next;
                low_reg[i] <= low_prev << 1;
                quo_reg[i] <= {quo_prev[QUO_W-2:0], ge};
                den_reg[i] <= den_prev;
            end
        end
    end

    assign quo = quo_reg[QUO_W-1];
    assign rem = rem_reg[QUO_W-1];

endmodule

`default_nettype wire

// File: rtl/pbm_horner.sv
// One Horner step p' = 1 - (x*p)/DIVISOR, saturated at zero, over two register stages.
// Depends on pbm_pkg; used by periodic_band_map_pixel_core for exp, sin and cos series.
`timescale 1ns / 1ps
`default_nettype none

module pbm_horner
    import pbm_pkg::*;
#(
    parameter int DIVISOR = 1
) (
    input  wire         clk,
    input  wire         en,
    input  wire  [31:0] x,
    input  wire  [30:0] p_in,
    output logic [30:0] p_out
);

    // reciprocal that makes floor(a/DIVISOR) exact for any 32-bit a
    localparam int          L   = $clog2(DIVISOR);
    localparam int          SH  = 32 + L;
    localparam logic [63:0] M64 = ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [32:0] M   = 33'(M64);

    logic [31:0] a_reg;
    logic [31:0] a_next;
    logic [30:0] p_reg;
    logic [30:0] p_next;
    logic [65:0] prod;
    logic [32:0] term;

    // first stage: x*p in Q30
    assign a_next = 32'((64'(x) * 64'(p_in)) >> Q);

    // second stage: divide by the constant, subtract from one
    always_comb
    begin
        prod   = 66'(a_reg) * 66'(M);
        term   = 33'(prod >> SH);
        p_next = (term > 33'(ONE_Q)) ? 31'd0 : 31'(33'(ONE_Q) - term);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg <= a_next;
            p_reg <= p_next;
        end
    end

    assign p_out = p_reg;

endmodule

`default_nettype wire
